FILE: rtl/core/motor_feedback_frame_tracker_core_assert.svh
// ----------------------------------------------------------------------------
// motor feedback frame tracker assertion macros
// implication checks, same cycle and next cycle, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_FRAME_TRACKER_CORE_ASSERT_SVH
`define MOTOR_FEEDBACK_FRAME_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFFT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define MFFT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MFFT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MFFT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/mfft_pkg.sv
// ----------------------------------------------------------------------------
// mfft_pkg
// shared constants, codes and types of the motor feedback frame tracker
// ----------------------------------------------------------------------------
package mfft_pkg;

   localparam int MOTOR_COUNT_DEFAULT = 4;
   localparam int FIRST_SLAVE         = 1;
   localparam int ID_BASE             = 16'h10;

   localparam int POS_BITS  = 16;
   localparam int VT_BITS   = 12;
   localparam int POS_RANGE = (2 ** POS_BITS) - 1;
   localparam int VT_RANGE  = (2 ** VT_BITS) - 1;

   localparam logic [31:0] POSITION_MIN_RESET = 32'hFFF3_8000;
   localparam logic [31:0] POSITION_MAX_RESET = 32'h000C_8000;
   localparam logic [31:0] VELOCITY_MIN_RESET = 32'hFF38_0000;
   localparam logic [31:0] VELOCITY_MAX_RESET = 32'h00C8_0000;
   localparam logic [31:0] TORQUE_MIN_RESET   = 32'hFFEC_0000;
   localparam logic [31:0] TORQUE_MAX_RESET   = 32'h0014_0000;

   typedef enum logic {
      OP_FRAME = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_FORMAT  = 3'd1,
      ST_ID_RANGE    = 3'd2,
      ST_BAD_SLAVE   = 3'd3,
      ST_ID_MISMATCH = 3'd4,
      ST_BAD_INDEX   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CFG_POSITION_MIN = 3'd0,
      CFG_POSITION_MAX = 3'd1,
      CFG_VELOCITY_MIN = 3'd2,
      CFG_VELOCITY_MAX = 3'd3,
      CFG_TORQUE_MIN   = 3'd4,
      CFG_TORQUE_MAX   = 3'd5
   } cfg_index_type;

endpackage

FILE: rtl/core/mfft_req_if.sv
// ----------------------------------------------------------------------------
// mfft_req_if
// request channel: received frame or online query
// ----------------------------------------------------------------------------
interface mfft_req_if import mfft_pkg::*; ();

   logic        valid;
   logic        ready;
   opcode_type  opcode;
   logic [10:0] identifier;
   logic        standard_id;
   logic        data_frame;
   logic [3:0]  data_length;
   logic [63:0] payload;
   logic [31:0] now_ms;
   logic [7:0]  query_index;
   logic [31:0] timeout_ms;

   modport source (
      output valid, opcode, identifier, standard_id, data_frame, data_length,
             payload, now_ms, query_index, timeout_ms,
      input  ready
   );

   modport sink (
      input  valid, opcode, identifier, standard_id, data_frame, data_length,
             payload, now_ms, query_index, timeout_ms,
      output ready
   );

endinterface

FILE: rtl/core/mfft_rsp_if.sv
// ----------------------------------------------------------------------------
// mfft_rsp_if
// response channel: status and motor record
// ----------------------------------------------------------------------------
interface mfft_rsp_if import mfft_pkg::*; ();

   logic        valid;
   logic        ready;
   status_type  status;
   logic [1:0]  motor_index;
   logic [3:0]  motor_state;
   logic [31:0] position;
   logic [31:0] velocity;
   logic [31:0] torque;
   logic [7:0]  driver_temp;
   logic [7:0]  rotor_temp;
   logic        online;
   logic [31:0] frame_count;

   modport source (
      output valid, status, motor_index, motor_state, position, velocity, torque,
             driver_temp, rotor_temp, online, frame_count,
      input  ready
   );

   modport sink (
      input  valid, status, motor_index, motor_state, position, velocity, torque,
             driver_temp, rotor_temp, online, frame_count,
      output ready
   );

endinterface

FILE: rtl/core/mfft_csr_if.sv
// ----------------------------------------------------------------------------
// mfft_csr_if
// register write channel: index and data
// ----------------------------------------------------------------------------
interface mfft_csr_if import mfft_pkg::*; ();

   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );

endinterface

FILE: rtl/core/motor_feedback_frame_tracker_core.sv
// ----------------------------------------------------------------------------
// motor_feedback_frame_tracker_core
// Decodes motor feedback frames and answers online queries.
// req_chan carries a received CAN frame (opcode frame) or a query (opcode
// query); each request gives exactly one response on rsp_chan, in order.
// A valid frame is unpacked, its position, velocity and torque codes are
// scaled to Q15.16 between the configured limits, and the record of its
// motor is updated with a time stamp and a wrapping frame count.
// csr_chan writes the six limit registers; it is always ready and must only
// be used while no request is in flight.
// Throughput: one request per cycle while responses are taken, through the four
// register stages (input, multiply, reciprocal divide, saturate and record update).
// Records are read and written only in the last stage, so back to back
// requests to one motor see each other in order.
// A stalled response holds the output stage; earlier stages keep filling
// until all four are full, then req_chan.ready drops.
// Reset clears the limits to their defaults and all records.
// ----------------------------------------------------------------------------
`include "motor_feedback_frame_tracker_core_assert.svh"

module motor_feedback_frame_tracker_core import mfft_pkg::*; #(
   parameter int MOTOR_COUNT = MOTOR_COUNT_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   mfft_req_if.sink  req_chan,
   mfft_rsp_if.source rsp_chan,
   mfft_csr_if.sink  csr_chan
);

   localparam int IDX_W    = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam int ID_LO    = ID_BASE + FIRST_SLAVE;
   localparam int ID_HI    = ID_BASE + FIRST_SLAVE + MOTOR_COUNT - 1;
   localparam int SLAVE_HI = FIRST_SLAVE + MOTOR_COUNT - 1;

   typedef struct packed {
      opcode_type  opcode;
      logic [10:0] identifier;
      logic        standard_id;
      logic        data_frame;
      logic [3:0]  data_length;
      logic [63:0] payload;
      logic [31:0] now_ms;
      logic [7:0]  query_index;
      logic [31:0] timeout_ms;
   } req_item_type;

   typedef struct packed {
      opcode_type       opcode;
      status_type       status;
      logic [IDX_W-1:0] idx;
      logic [3:0]       motor_state;
      logic [7:0]       driver_temp;
      logic [7:0]       rotor_temp;
      logic [31:0]      now_ms;
      logic [31:0]      timeout_ms;
   } ctl_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  motor_index;
      logic [3:0]  motor_state;
      logic [31:0] position;
      logic [31:0] velocity;
      logic [31:0] torque;
      logic [7:0]  driver_temp;
      logic [7:0]  rotor_temp;
      logic        online;
      logic [31:0] frame_count;
   } rec_type;

   // {negative, magnitude} of max - min
   function automatic logic [32:0] span_mag(input logic [31:0] lo, input logic [31:0] hi);
      logic [32:0] span;
      logic [32:0] mag;
      span = {hi[31], hi} - {lo[31], lo};
      mag  = span[32] ? (33'd0 - span) : span;
      return {span[32], mag[31:0]};
   endfunction

   function automatic logic [31:0] div_pos(input logic [48:0] x);
      logic [49:0] s;
      logic [33:0] qe;
      logic [49:0] r;
      s  = 50'(x) + 50'(x[48:16]) + 50'(x[48:32]);
      qe = s[49:16];
      r  = 50'(x) + 50'(qe) - {qe, 16'b0};
      return (r >= 50'(POS_RANGE)) ? (qe[31:0] + 32'd1) : qe[31:0];
   endfunction

   function automatic logic [31:0] div_vt(input logic [44:0] x);
      logic [45:0] s;
      logic [33:0] qe;
      logic [45:0] r;
      s  = 46'(x) + 46'(x[44:12]) + 46'(x[44:24]) + 46'(x[44:36]);
      qe = s[45:12];
      r  = 46'(x) + 46'(qe) - {qe, 12'b0};
      return (r >= 46'(VT_RANGE)) ? (qe[31:0] + 32'd1) : qe[31:0];
   endfunction

   function automatic logic [31:0] sat_sum(input logic [31:0] lo, input logic neg,
                                           input logic [31:0] q);
      logic [33:0] s;
      logic [33:0] s_lo;
      logic [33:0] s_q;
      s_lo = {{2{lo[31]}}, lo};
      s_q  = {2'b00, q};
      s    = neg ? (s_lo - s_q) : (s_lo + s_q);
      if (!s[33] && (s[32:31] != 2'b00)) begin
         return 32'h7FFF_FFFF;
      end else if (s[33] && (s[32:31] != 2'b11)) begin
         return 32'h8000_0000;
      end else begin
         return s[31:0];
      end
   endfunction

   // limit registers and derived spans
   logic [31:0] pos_min_ff, pos_max_ff, vel_min_ff, vel_max_ff, tor_min_ff, tor_max_ff;
   logic [32:0] pos_span_ff, vel_span_ff, tor_span_ff;

   // pipeline
   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   logic         adv1, adv2, adv3, adv4;
   req_item_type in1_ff, in1_in;
   ctl_type      ctl2_ff, ctl2_in, ctl3_ff;
   logic [47:0]  pos_prod_ff, pos_prod_in;
   logic [43:0]  vel_prod_ff, vel_prod_in;
   logic [43:0]  tor_prod_ff, tor_prod_in;
   logic [31:0]  pos_q_ff, pos_q_in, vel_q_ff, vel_q_in, tor_q_ff, tor_q_in;
   rec_type      rsp_rec_ff, rsp_rec_in;
   logic         store_we;

   // motor records
   logic [3:0]  state_ff  [MOTOR_COUNT];
   logic [31:0] posst_ff  [MOTOR_COUNT];
   logic [31:0] velst_ff  [MOTOR_COUNT];
   logic [31:0] torst_ff  [MOTOR_COUNT];
   logic [7:0]  dtemp_ff  [MOTOR_COUNT];
   logic [7:0]  rtemp_ff  [MOTOR_COUNT];
   logic [31:0] stamp_ff  [MOTOR_COUNT];
   logic [31:0] count_ff  [MOTOR_COUNT];
   logic        seen_ff   [MOTOR_COUNT];

   assign adv4 = !v4_ff || rsp_chan.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req_chan.ready = adv1;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      in1_in.opcode      = req_chan.opcode;
      in1_in.identifier  = req_chan.identifier;
      in1_in.standard_id = req_chan.standard_id;
      in1_in.data_frame  = req_chan.data_frame;
      in1_in.data_length = req_chan.data_length;
      in1_in.payload     = req_chan.payload;
      in1_in.now_ms      = req_chan.now_ms;
      in1_in.query_index = req_chan.query_index;
      in1_in.timeout_ms  = req_chan.timeout_ms;
   end

   // decode and multiply
   logic [3:0] slave;
   logic [3:0] slave_off;

   always_comb begin
      slave     = in1_ff.payload[59:56];
      slave_off = slave - 4'(FIRST_SLAVE);

      ctl2_in.opcode      = in1_ff.opcode;
      ctl2_in.status      = ST_OK;
      ctl2_in.idx         = '0;
      ctl2_in.motor_state = in1_ff.payload[63:60];
      ctl2_in.driver_temp = in1_ff.payload[15:8];
      ctl2_in.rotor_temp  = in1_ff.payload[7:0];
      ctl2_in.now_ms      = in1_ff.now_ms;
      ctl2_in.timeout_ms  = in1_ff.timeout_ms;

      if (in1_ff.opcode == OP_QUERY) begin
         if (int'(in1_ff.query_index) >= MOTOR_COUNT) begin
            ctl2_in.status = ST_BAD_INDEX;
         end else begin
            ctl2_in.idx = IDX_W'(in1_ff.query_index);
         end
      end else if (!in1_ff.standard_id || !in1_ff.data_frame ||
                   (in1_ff.data_length != 4'd8)) begin
         ctl2_in.status = ST_BAD_FORMAT;
      end else if ((int'(in1_ff.identifier) < ID_LO) || (int'(in1_ff.identifier) > ID_HI)) begin
         ctl2_in.status = ST_ID_RANGE;
      end else if ((int'(slave) < FIRST_SLAVE) || (int'(slave) > SLAVE_HI)) begin
         ctl2_in.status = ST_BAD_SLAVE;
      end else if (in1_ff.identifier != (11'(slave) + 11'(ID_BASE))) begin
         ctl2_in.status = ST_ID_MISMATCH;
      end else begin
         ctl2_in.idx = IDX_W'(slave_off);
      end

      pos_prod_in = 48'(in1_ff.payload[55:40]) * 48'(pos_span_ff[31:0]);
      vel_prod_in = 44'(in1_ff.payload[39:28]) * 44'(vel_span_ff[31:0]);
      tor_prod_in = 44'(in1_ff.payload[27:16]) * 44'(tor_span_ff[31:0]);
   end

   // rounded division by the full-scale code
   always_comb begin
      pos_q_in = div_pos(49'(pos_prod_ff) + 49'(POS_RANGE / 2));
      vel_q_in = div_vt(45'(vel_prod_ff) + 45'(VT_RANGE / 2));
      tor_q_in = div_vt(45'(tor_prod_ff) + 45'(VT_RANGE / 2));
   end

   // saturate, record read and update
   logic [3:0]  idx_wide;
   logic [31:0] age;

   always_comb begin
      idx_wide = 4'(ctl3_ff.idx);
      age      = ctl3_ff.now_ms - stamp_ff[ctl3_ff.idx];
      store_we = adv4 && v3_ff && (ctl3_ff.status == ST_OK) && (ctl3_ff.opcode == OP_FRAME);

      rsp_rec_in = '0;
      rsp_rec_in.status = ctl3_ff.status;
      if (ctl3_ff.status == ST_OK) begin
         rsp_rec_in.motor_index = idx_wide[1:0];
         if (ctl3_ff.opcode == OP_FRAME) begin
            rsp_rec_in.motor_state = ctl3_ff.motor_state;
            rsp_rec_in.position    = sat_sum(pos_min_ff, pos_span_ff[32], pos_q_ff);
            rsp_rec_in.velocity    = sat_sum(vel_min_ff, vel_span_ff[32], vel_q_ff);
            rsp_rec_in.torque      = sat_sum(tor_min_ff, tor_span_ff[32], tor_q_ff);
            rsp_rec_in.driver_temp = ctl3_ff.driver_temp;
            rsp_rec_in.rotor_temp  = ctl3_ff.rotor_temp;
            rsp_rec_in.online      = 1'b1;
            rsp_rec_in.frame_count = count_ff[ctl3_ff.idx] + 32'd1;
         end else begin
            rsp_rec_in.motor_state = state_ff[ctl3_ff.idx];
            rsp_rec_in.position    = posst_ff[ctl3_ff.idx];
            rsp_rec_in.velocity    = velst_ff[ctl3_ff.idx];
            rsp_rec_in.torque      = torst_ff[ctl3_ff.idx];
            rsp_rec_in.driver_temp = dtemp_ff[ctl3_ff.idx];
            rsp_rec_in.rotor_temp  = rtemp_ff[ctl3_ff.idx];
            rsp_rec_in.online      = seen_ff[ctl3_ff.idx] && (age <= ctl3_ff.timeout_ms);
            rsp_rec_in.frame_count = count_ff[ctl3_ff.idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_span_ff <= span_mag(pos_min_ff, pos_max_ff);
      vel_span_ff <= span_mag(vel_min_ff, vel_max_ff);
      tor_span_ff <= span_mag(tor_min_ff, tor_max_ff);

      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         pos_min_ff <= POSITION_MIN_RESET;
         pos_max_ff <= POSITION_MAX_RESET;
         vel_min_ff <= VELOCITY_MIN_RESET;
         vel_max_ff <= VELOCITY_MAX_RESET;
         tor_min_ff <= TORQUE_MIN_RESET;
         tor_max_ff <= TORQUE_MAX_RESET;
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            state_ff[i] <= '0;
            posst_ff[i] <= '0;
            velst_ff[i] <= '0;
            torst_ff[i] <= '0;
            dtemp_ff[i] <= '0;
            rtemp_ff[i] <= '0;
            stamp_ff[i] <= '0;
            count_ff[i] <= '0;
            seen_ff[i]  <= 1'b0;
         end
      end else begin
         if (csr_chan.valid) begin
            unique case (cfg_index_type'(csr_chan.index))
               CFG_POSITION_MIN: pos_min_ff <= csr_chan.data;
               CFG_POSITION_MAX: pos_max_ff <= csr_chan.data;
               CFG_VELOCITY_MIN: vel_min_ff <= csr_chan.data;
               CFG_VELOCITY_MAX: vel_max_ff <= csr_chan.data;
               CFG_TORQUE_MIN:   tor_min_ff <= csr_chan.data;
               CFG_TORQUE_MAX:   tor_max_ff <= csr_chan.data;
               default: ;
            endcase
         end

         if (adv1) begin
            v1_ff <= req_chan.valid;
            if (req_chan.valid) begin
               in1_ff <= in1_in;
            end
         end
         if (adv2) begin
            v2_ff <= v1_ff;
            if (v1_ff) begin
               ctl2_ff     <= ctl2_in;
               pos_prod_ff <= pos_prod_in;
               vel_prod_ff <= vel_prod_in;
               tor_prod_ff <= tor_prod_in;
            end
         end
         if (adv3) begin
            v3_ff <= v2_ff;
            if (v2_ff) begin
               ctl3_ff  <= ctl2_ff;
               pos_q_ff <= pos_q_in;
               vel_q_ff <= vel_q_in;
               tor_q_ff <= tor_q_in;
            end
         end
         if (adv4) begin
            v4_ff <= v3_ff;
            if (v3_ff) begin
               rsp_rec_ff <= rsp_rec_in;
            end
         end

         if (store_we) begin
            state_ff[ctl3_ff.idx] <= rsp_rec_in.motor_state;
            posst_ff[ctl3_ff.idx] <= rsp_rec_in.position;
            velst_ff[ctl3_ff.idx] <= rsp_rec_in.velocity;
            torst_ff[ctl3_ff.idx] <= rsp_rec_in.torque;
            dtemp_ff[ctl3_ff.idx] <= rsp_rec_in.driver_temp;
            rtemp_ff[ctl3_ff.idx] <= rsp_rec_in.rotor_temp;
            stamp_ff[ctl3_ff.idx] <= ctl3_ff.now_ms;
            count_ff[ctl3_ff.idx] <= rsp_rec_in.frame_count;
            seen_ff[ctl3_ff.idx]  <= 1'b1;
         end
      end
   end

   assign rsp_chan.valid       = v4_ff;
   assign rsp_chan.status      = rsp_rec_ff.status;
   assign rsp_chan.motor_index = rsp_rec_ff.motor_index;
   assign rsp_chan.motor_state = rsp_rec_ff.motor_state;
   assign rsp_chan.position    = rsp_rec_ff.position;
   assign rsp_chan.velocity    = rsp_rec_ff.velocity;
   assign rsp_chan.torque      = rsp_rec_ff.torque;
   assign rsp_chan.driver_temp = rsp_rec_ff.driver_temp;
   assign rsp_chan.rotor_temp  = rsp_rec_ff.rotor_temp;
   assign rsp_chan.online      = rsp_rec_ff.online;
   assign rsp_chan.frame_count = rsp_rec_ff.frame_count;

   `MFFT_ASSERT_IMP(a_stall_only_when_full, clock, reset, !req_chan.ready, v1_ff && v2_ff && v3_ff && v4_ff, "request stalled with an empty stage")
   `MFFT_ASSERT_IMP(a_error_clears_record, clock, reset, v4_ff && (rsp_rec_ff.status != ST_OK), (rsp_rec_ff.frame_count == 32'd0) && !rsp_rec_ff.online && (rsp_rec_ff.position == 32'd0), "error response carries record data")
   `MFFT_ASSERT_NXT(a_frame_marks_seen, clock, reset, store_we && (ctl3_ff.idx == '0), seen_ff[0] && (stamp_ff[0] == $past(ctl3_ff.now_ms)), "record update lost")
   `MFFT_ASSERT_IMP(a_unseen_is_clear, clock, reset, !seen_ff[0], (count_ff[0] == 32'd0) && (stamp_ff[0] == 32'd0), "unseen motor has a count or stamp")

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for motor_feedback_frame_tracker_core. Frames and online
// queries go in on the request channel. A behavioral copy of the motor
// records and the scaling limits predicts every response: format, range,
// slave and mismatch rejects, the Q15.16 scaling, stamps, counts and the age
// window. Directed cases come first, then random traffic under several limit
// settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
   import mfft_pkg::*;

   localparam int MOTORS          = MOTOR_COUNT_DEFAULT;
   localparam int REG_COUNT       = int'(CFG_TORQUE_MAX) + 1;
   localparam logic [3:0] FULL_DLC = 4'd8;
   localparam logic [2:0] CFG_SPARE_LOW  = 3'd6;
   localparam logic [2:0] CFG_SPARE_HIGH = 3'd7;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 280;

   typedef enum {
      LIMITS_DEFAULT,
      LIMITS_FULL,
      LIMITS_INVERTED,
      LIMITS_FLAT,
      LIMITS_RANDOM
   } limit_setting_t;

   typedef struct {
      opcode_type  opcode;
      logic [10:0] identifier;
      logic        standard_id;
      logic        data_frame;
      logic [3:0]  data_length;
      logic [63:0] payload;
      logic [31:0] now_ms;
      logic [7:0]  query_index;
      logic [31:0] timeout_ms;
   } frame_request_t;

   typedef struct {
      status_type  status;
      logic [1:0]  motor_index;
      logic [3:0]  motor_state;
      logic [31:0] position;
      logic [31:0] velocity;
      logic [31:0] torque;
      logic [7:0]  driver_temp;
      logic [7:0]  rotor_temp;
      logic        online;
      logic [31:0] frame_count;
   } motor_record_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mfft_req_if req ();
   mfft_rsp_if rsp ();
   mfft_csr_if csr ();

   motor_feedback_frame_tracker_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   // predicted limits and motor records
   logic [31:0] limit_reg    [REG_COUNT];
   logic [3:0]  state_mem    [MOTORS];
   logic [31:0] position_mem [MOTORS];
   logic [31:0] velocity_mem [MOTORS];
   logic [31:0] torque_mem   [MOTORS];
   logic [7:0]  driver_mem   [MOTORS];
   logic [7:0]  rotor_mem    [MOTORS];
   logic [31:0] stamp_mem    [MOTORS];
   logic [31:0] count_mem    [MOTORS];
   logic        seen_mem     [MOTORS];

   motor_record_t expected_records [$];
   int          mismatch_count = 0;
   int          quiet_cycles   = 0;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   logic [31:0] tick_ms;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] scale_code(logic [15:0] code, logic [31:0] lo_bits,
                                              logic [31:0] hi_bits, int bits);
      longint          lo;
      longint          span;
      longint          total;
      longint unsigned steps;
      longint unsigned mag;
      longint unsigned quot;
      lo    = longint'($signed(lo_bits));
      span  = longint'($signed(hi_bits)) - lo;
      steps = (64'd1 << bits) - 64'd1;
      mag   = (span < 0) ? -span : span;
      // round half away from zero on the magnitude
      quot  = ({48'd0, code} * mag + steps / 64'd2) / steps;
      total = (span < 0) ? lo - longint'(quot) : lo + longint'(quot);
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      if (total < -64'sd2147483648) total = -64'sd2147483648;
      return total[31:0];
   endfunction

   function automatic motor_record_t blank_record(status_type st);
      motor_record_t r;
      r.status      = st;
      r.motor_index = '0;
      r.motor_state = '0;
      r.position    = '0;
      r.velocity    = '0;
      r.torque      = '0;
      r.driver_temp = '0;
      r.rotor_temp  = '0;
      r.online      = 1'b0;
      r.frame_count = '0;
      return r;
   endfunction

   function automatic motor_record_t read_record(int idx, logic [31:0] now,
                                                 logic [31:0] timeout);
      motor_record_t r;
      logic [31:0]   age;
      age           = now - stamp_mem[idx];
      r.status      = ST_OK;
      r.motor_index = 2'(idx);
      r.motor_state = state_mem[idx];
      r.position    = position_mem[idx];
      r.velocity    = velocity_mem[idx];
      r.torque      = torque_mem[idx];
      r.driver_temp = driver_mem[idx];
      r.rotor_temp  = rotor_mem[idx];
      r.online      = seen_mem[idx] && (age <= timeout);
      r.frame_count = count_mem[idx];
      return r;
   endfunction

   function automatic motor_record_t decode_request(frame_request_t q);
      int          slave;
      int          idx;
      logic [63:0] p;
      p = q.payload;
      if (q.opcode == OP_QUERY) begin
         if (q.query_index >= MOTORS) return blank_record(ST_BAD_INDEX);
         return read_record(int'(q.query_index), q.now_ms, q.timeout_ms);
      end
      if (!q.standard_id || !q.data_frame || q.data_length != FULL_DLC)
         return blank_record(ST_BAD_FORMAT);
      if (q.identifier < ID_BASE + FIRST_SLAVE ||
          q.identifier > ID_BASE + FIRST_SLAVE + MOTORS - 1)
         return blank_record(ST_ID_RANGE);
      slave = int'(p[59:56]);
      if (slave < FIRST_SLAVE || slave > FIRST_SLAVE + MOTORS - 1)
         return blank_record(ST_BAD_SLAVE);
      if (q.identifier != ID_BASE + slave) return blank_record(ST_ID_MISMATCH);
      idx = slave - FIRST_SLAVE;
      state_mem[idx]    = p[63:60];
      position_mem[idx] = scale_code(p[55:40], limit_reg[CFG_POSITION_MIN],
                                     limit_reg[CFG_POSITION_MAX], POS_BITS);
      velocity_mem[idx] = scale_code(16'(p[39:28]), limit_reg[CFG_VELOCITY_MIN],
                                     limit_reg[CFG_VELOCITY_MAX], VT_BITS);
      torque_mem[idx]   = scale_code(16'(p[27:16]), limit_reg[CFG_TORQUE_MIN],
                                     limit_reg[CFG_TORQUE_MAX], VT_BITS);
      driver_mem[idx]   = p[15:8];
      rotor_mem[idx]    = p[7:0];
      stamp_mem[idx]    = q.now_ms;
      count_mem[idx]    = count_mem[idx] + 32'd1;
      seen_mem[idx]     = 1'b1;
      return read_record(idx, q.now_ms, q.timeout_ms);
   endfunction

   function automatic logic [63:0] pack_payload(logic [3:0] st, logic [3:0] slave,
                                                logic [15:0] pos, logic [11:0] vel,
                                                logic [11:0] tq, logic [7:0] dt,
                                                logic [7:0] rt);
      return {st, slave, pos, vel, tq, dt, rt};
   endfunction

   function automatic frame_request_t make_frame(logic [10:0] ident, logic std, logic dat,
                                                 logic [3:0] dlc, logic [63:0] payload,
                                                 logic [31:0] now, logic [31:0] timeout);
      frame_request_t r;
      r.opcode      = OP_FRAME;
      r.identifier  = ident;
      r.standard_id = std;
      r.data_frame  = dat;
      r.data_length = dlc;
      r.payload     = payload;
      r.now_ms      = now;
      r.query_index = 8'($urandom_range(255));
      r.timeout_ms  = timeout;
      return r;
   endfunction

   function automatic frame_request_t make_query(logic [7:0] index, logic [31:0] now,
                                                 logic [31:0] timeout);
      frame_request_t r;
      r = make_frame(11'($urandom_range(2047)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 4'($urandom_range(15)),
                     {$urandom, $urandom}, now, timeout);
      r.opcode      = OP_QUERY;
      r.query_index = index;
      return r;
   endfunction

   function automatic logic [31:0] advance_tick();
      if ($urandom_range(99) < 3) tick_ms = $urandom;
      else tick_ms = tick_ms + $urandom_range(4);
      return tick_ms;
   endfunction

   function automatic logic [31:0] pick_timeout();
      case ($urandom_range(3))
         0: return '0;
         1: return 32'($urandom_range(8));
         2: return $urandom;
         default: return '1;
      endcase
   endfunction

   function automatic frame_request_t random_request();
      frame_request_t r;
      logic [3:0]     slave;
      int             pick;
      pick  = $urandom_range(99);
      slave = 4'(FIRST_SLAVE + $urandom_range(MOTORS - 1));
      r = make_frame(11'(ID_BASE + slave), 1'b1, 1'b1, FULL_DLC, {$urandom, $urandom},
                     advance_tick(), pick_timeout());
      r.payload[59:56] = slave;
      if (pick >= 55 && pick < 80) begin
         r = make_query(($urandom_range(9) == 0) ? 8'($urandom) :
                        8'($urandom_range(MOTORS - 1)), r.now_ms, r.timeout_ms);
      end else if (pick >= 80 && pick < 90) begin
         // one field of an otherwise good frame set at random, mostly to a bad value
         case ($urandom_range(5))
            0: r.standard_id = 1'b0;
            1: r.data_frame = 1'b0;
            2: r.data_length = 4'($urandom_range(15));
            3: r.identifier = 11'($urandom_range(2047));
            4: r.payload[59:56] = 4'($urandom_range(15));
            default: r.identifier = 11'(ID_BASE + FIRST_SLAVE + $urandom_range(MOTORS - 1));
         endcase
      end else if (pick >= 90) begin
         r.opcode      = $urandom_range(1) ? OP_QUERY : OP_FRAME;
         r.identifier  = 11'($urandom_range(2047));
         r.standard_id = 1'($urandom_range(1));
         r.data_frame  = 1'($urandom_range(1));
         r.data_length = 4'($urandom_range(15));
         r.query_index = 8'($urandom_range(255));
         r.now_ms      = $urandom;
         r.timeout_ms  = $urandom;
      end
      return r;
   endfunction

   task automatic send_request(frame_request_t q);
      while ($urandom_range(99) < sender_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.opcode      <= q.opcode;
      req.identifier  <= q.identifier;
      req.standard_id <= q.standard_id;
      req.data_frame  <= q.data_frame;
      req.data_length <= q.data_length;
      req.payload     <= q.payload;
      req.now_ms      <= q.now_ms;
      req.query_index <= q.query_index;
      req.timeout_ms  <= q.timeout_ms;
      do @(posedge clock); while (req.ready !== 1'b1);
      expected_records.push_back(decode_request(q));
   endtask

   task automatic drain_responses();
      req.valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [31:0] value);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data  <= value;
      do @(posedge clock); while (csr.ready !== 1'b1);
      if (index < REG_COUNT) limit_reg[index] = value;
   endtask

   task automatic apply_limits(limit_setting_t setting);
      logic [31:0] lim [REG_COUNT];
      logic [31:0] pick;
      // registers alternate min, max
      case (setting)
         LIMITS_DEFAULT: begin
            lim[CFG_POSITION_MIN] = POSITION_MIN_RESET;
            lim[CFG_POSITION_MAX] = POSITION_MAX_RESET;
            lim[CFG_VELOCITY_MIN] = VELOCITY_MIN_RESET;
            lim[CFG_VELOCITY_MAX] = VELOCITY_MAX_RESET;
            lim[CFG_TORQUE_MIN]   = TORQUE_MIN_RESET;
            lim[CFG_TORQUE_MAX]   = TORQUE_MAX_RESET;
         end
         LIMITS_FULL: begin
            write_register(CFG_SPARE_LOW, $urandom);
            write_register(CFG_SPARE_HIGH, $urandom);
            foreach (lim[i]) lim[i] = (i % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
         LIMITS_INVERTED: begin
            foreach (lim[i]) lim[i] = (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         end
         LIMITS_FLAT: begin
            foreach (lim[i]) begin
               if (i % 2 == 0) pick = $urandom;
               lim[i] = pick;
            end
         end
         default: begin
            foreach (lim[i]) lim[i] = $urandom;
         end
      endcase
      foreach (lim[i]) write_register(3'(i), lim[i]);
      csr.valid <= 1'b0;
   endtask

   task automatic test_reset_records();
      for (int m = 0; m < MOTORS; m++) send_request(make_query(8'(m), '0, '1));
      send_request(make_query(8'(MOTORS), $urandom, $urandom));
      send_request(make_query(8'hFF, $urandom, $urandom));
   endtask

   task automatic test_frame_rejects();
      logic [63:0] good;
      logic [63:0] slave_low;
      logic [63:0] slave_high;
      good       = pack_payload(4'h3, 4'(FIRST_SLAVE), 16'h1234, 12'h567, 12'h89A, 8'h40, 8'h41);
      slave_low  = pack_payload(4'h3, 4'(FIRST_SLAVE - 1), 16'h0, 12'h0, 12'h0, 8'h0, 8'h0);
      slave_high = pack_payload(4'h3, 4'hF, 16'h0, 12'h0, 12'h0, 8'h0, 8'h0);
      // format failure wins over a bad identifier
      send_request(make_frame(11'h7FF, 1'b0, 1'b1, FULL_DLC, good, 32'd10, '1));
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE), 1'b1, 1'b0, FULL_DLC, good,
                              32'd10, '1));
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE), 1'b1, 1'b1, 4'hF, good, 32'd10, '1));
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE), 1'b1, 1'b1, 4'h0, good, 32'd10, '1));
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE - 1), 1'b1, 1'b1, FULL_DLC, good,
                              32'd10, '1));
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE + MOTORS), 1'b1, 1'b1, FULL_DLC, good,
                              32'd10, '1));
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE), 1'b1, 1'b1, FULL_DLC, slave_low,
                              32'd10, '1));
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE), 1'b1, 1'b1, FULL_DLC, slave_high,
                              32'd10, '1));
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE + 1), 1'b1, 1'b1, FULL_DLC, good,
                              32'd10, '1));
   endtask

   task automatic test_scaling_extremes();
      logic [63:0] mid;
      mid = pack_payload(4'h5, 4'(FIRST_SLAVE + 1), 16'h8000, 12'h800, 12'h7FF, 8'h80, 8'h01);
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE + MOTORS - 1), 1'b1, 1'b1, FULL_DLC,
                              pack_payload(4'hF, 4'(FIRST_SLAVE + MOTORS - 1), 16'hFFFF,
                                           12'hFFF, 12'hFFF, 8'hFF, 8'hFF),
                              32'hFFFF_FFFF, '0));
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE), 1'b1, 1'b1, FULL_DLC,
                              pack_payload(4'h0, 4'(FIRST_SLAVE), 16'h0, 12'h0, 12'h0,
                                           8'h0, 8'h0),
                              32'd0, '0));
      // same identifier back to back, the second with an inverted payload and so a bad slave
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE + 1), 1'b1, 1'b1, FULL_DLC, mid,
                              32'd100, 32'd5));
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE + 1), 1'b1, 1'b1, FULL_DLC, ~mid,
                              32'd101, 32'd5));
   endtask

   task automatic test_online_window();
      send_request(make_frame(11'(ID_BASE + FIRST_SLAVE + 2), 1'b1, 1'b1, FULL_DLC,
                              pack_payload(4'hA, 4'(FIRST_SLAVE + 2), 16'h00FF, 12'h0F0,
                                           12'hF0F, 8'h12, 8'h34),
                              32'hFFFF_FFFE, '0));
      // age wraps through zero
      send_request(make_query(8'd2, 32'hFFFF_FFFE, '0));
      send_request(make_query(8'd2, 32'd3, 32'd5));
      send_request(make_query(8'd2, 32'd3, 32'd4));
   endtask

   task automatic test_random_traffic();
      limit_setting_t plan [PHASES] = '{LIMITS_DEFAULT, LIMITS_FULL, LIMITS_INVERTED,
                                         LIMITS_FLAT, LIMITS_RANDOM, LIMITS_RANDOM};
      int sender_plan   [PHASES] = '{10, 10, 58, 58, 0, 0};
      int receiver_plan [PHASES] = '{58, 58, 10, 10, 0, 0};
      for (int p = 0; p < PHASES; p++) begin
         drain_responses();
         apply_limits(plan[p]);
         sender_idle_pct    = sender_plan[p];
         receiver_stall_pct = receiver_plan[p];
         repeat (ITEMS_PER_PHASE) send_request(random_request());
      end
   endtask

   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : response_check
      motor_record_t want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (expected_records.size() == 0) begin
            $display("%0t: response with no request outstanding, status %0h",
                     $time, rsp.status);
            mismatch_count++;
         end else begin
            want = expected_records.pop_front();
            check_field("status", 32'(want.status), 32'(rsp.status));
            check_field("motor_index", 32'(want.motor_index), 32'(rsp.motor_index));
            check_field("motor_state", 32'(want.motor_state), 32'(rsp.motor_state));
            check_field("position", want.position, rsp.position);
            check_field("velocity", want.velocity, rsp.velocity);
            check_field("torque", want.torque, rsp.torque);
            check_field("driver_temp", 32'(want.driver_temp), 32'(rsp.driver_temp));
            check_field("rotor_temp", 32'(want.rotor_temp), 32'(rsp.rotor_temp));
            check_field("online", 32'(want.online), 32'(rsp.online));
            check_field("frame_count", want.frame_count, rsp.frame_count);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1) ||
          (csr.valid === 1'b1 && csr.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      req.valid       = 1'b0;
      req.opcode      = OP_FRAME;
      req.identifier  = '0;
      req.standard_id = 1'b0;
      req.data_frame  = 1'b0;
      req.data_length = '0;
      req.payload     = '0;
      req.now_ms      = '0;
      req.query_index = '0;
      req.timeout_ms  = '0;
      csr.valid       = 1'b0;
      csr.index       = CFG_POSITION_MIN;
      csr.data        = '0;
      rsp.ready       = 1'b0;

      limit_reg[CFG_POSITION_MIN] = POSITION_MIN_RESET;
      limit_reg[CFG_POSITION_MAX] = POSITION_MAX_RESET;
      limit_reg[CFG_VELOCITY_MIN] = VELOCITY_MIN_RESET;
      limit_reg[CFG_VELOCITY_MAX] = VELOCITY_MAX_RESET;
      limit_reg[CFG_TORQUE_MIN]   = TORQUE_MIN_RESET;
      limit_reg[CFG_TORQUE_MAX]   = TORQUE_MAX_RESET;
      for (int m = 0; m < MOTORS; m++) begin
         state_mem[m]    = '0;
         position_mem[m] = '0;
         velocity_mem[m] = '0;
         torque_mem[m]   = '0;
         driver_mem[m]   = '0;
         rotor_mem[m]    = '0;
         stamp_mem[m]    = '0;
         count_mem[m]    = '0;
         seen_mem[m]     = 1'b0;
      end
      sender_idle_pct    = 10;
      receiver_stall_pct = 58;
      tick_ms            = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_records();
      test_frame_rejects();
      test_scaling_extremes();
      test_online_window();
      test_random_traffic();
      drain_responses();

      if (mismatch_count == 0 && expected_records.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
